### src/wsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the weighted 3x3 smoothing filter: pixel type, item kinds,
// result source codes and the control word carried by the compute stage.
// No dependencies.
package wsf_pkg;

    typedef logic [7:0] pixel_t;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int FRAME_W_W = 11;
    localparam int FRAME_H_W = 12;
    localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RESET  = 11'd10;
    localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RESET = 12'd10;
    localparam logic [FRAME_H_W-1:0] MIN_HEIGHT = 12'd3;

    typedef logic [1:0] res_sel_t;
    localparam res_sel_t SEL_WINDOW    = 2'd0;
    localparam res_sel_t SEL_ABOVE_END = 2'd1;
    localparam res_sel_t SEL_CURRENT   = 2'd2;

    typedef struct packed {
        logic     is_pixel;
        logic     has_result;
        res_sel_t sel;
        logic     avg;
        logic     row_end;
        logic     frame_end;
    } stage_ctrl_t;

endpackage
`default_nettype wire

### src/weighted_3x3_smoothing_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Weighted 3x3 smoothing filter: two line buffers, 3x3 window, one compute stage
// and an output register. Depends on wsf_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------
//  in      | in_valid / in_stall | kind, pixel_in
//  out     | out_valid/out_stall | pixel_out, row_end, frame_end
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// One word per clock in steady state while in_stall is low; a taken word waits in
// the compute stage (line buffer read on the taking edge, window sum before the
// output register) and moves into the output register when that stage advances.
// Reset clears counters, window and valids; line buffers are not cleared.
// out_stall holds the output register and back-pressures in_stall only when
// the compute stage holds a result that cannot move.
module weighted_3x3_smoothing_filter_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          kind,
    input  wire wsf_pkg::pixel_t               pixel_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output wsf_pkg::pixel_t                    pixel_out,
    output logic                               row_end,
    output logic                               frame_end,
    input  wire logic                          cfg_we,
    input  wire logic [wsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wsf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wsf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    // configuration
    logic [FRAME_W_W-1:0] frame_width_reg;
    logic [FRAME_H_W-1:0] frame_height_reg;
    logic [WW-1:0]        eff_w;
    logic [FRAME_H_W-1:0] eff_h;
    logic [31:0]          fw32;

    // position counters
    logic [WW-1:0]        col_reg, col_next;
    logic [FRAME_H_W-1:0] row_reg, row_next;
    logic [PW-1:0]        pend_reg, pend_next;

    // line buffers
    pixel_t above_mem [MAX_WIDTH];
    pixel_t cur_mem   [MAX_WIDTH];
    pixel_t above_a_rd_reg, above_b_rd_reg, cur_rd_reg;
    logic   fwd_a_reg, fwd_b_reg, fwd_c_reg;
    pixel_t fwd_above_reg, fwd_cur_reg;
    logic [AW-1:0] addr_a, addr_b, addr_c;

    // compute stage
    logic          s1_valid_reg;
    stage_ctrl_t   s1_ctrl_reg, ctrl_next;
    logic [AW-1:0] s1_addr_reg;
    pixel_t        s1_pix_reg;
    logic          s1_adv, in_acc, mem_we;

    pixel_t window_reg [3][3];
    pixel_t a_eff, p_eff, b_eff, centre, result_val;
    logic [11:0] sum;

    // output register
    logic   out_valid_reg;
    pixel_t pixel_out_reg;
    logic   row_end_reg, frame_end_reg;

    // decode temporaries
    logic [WW-1:0]        c, d_m1, w_m1;
    logic [FRAME_H_W-1:0] r;
    logic [WW:0]          c_inc;
    logic [FRAME_H_W:0]   r_inc;
    logic                 flushed, last;

    always_comb
    begin
        fw32 = 32'(frame_width_reg);
        if (fw32 < 32'd3)
            eff_w = WW'(3);
        else if (fw32 > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(frame_width_reg);
        eff_h = (frame_height_reg < MIN_HEIGHT) ? MIN_HEIGHT : frame_height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_H_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv   = s1_valid_reg &&
                      (!s1_ctrl_reg.has_result || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_acc   = in_valid && !in_stall;
    assign mem_we   = s1_adv && s1_ctrl_reg.is_pixel;

    // word decode and counter update
    always_comb
    begin
        flushed   = (pend_reg != '0);
        last      = (pend_reg == PW'(1));
        c         = flushed ? '0 : col_reg;
        r         = flushed ? '0 : row_reg;
        c_inc     = {1'b0, c} + 1'b1;
        r_inc     = {1'b0, r} + 1'b1;
        d_m1      = col_reg - 1'b1;
        w_m1      = eff_w - 1'b1;
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        ctrl_next = '0;
        addr_a    = c[AW-1:0];
        addr_b    = w_m1[AW-1:0];
        addr_c    = c[AW-1:0];
        if (kind == KIND_PIXEL)
        begin
            ctrl_next.is_pixel = 1'b1;
            if (c != '0 && r != '0)
            begin
                ctrl_next.has_result = 1'b1;
                ctrl_next.sel        = SEL_WINDOW;
                ctrl_next.row_end    = (c >= eff_w);
                ctrl_next.avg        = !(r == FRAME_H_W'(1) || r >= eff_h ||
                                         c == WW'(1) || c >= eff_w);
            end
            else if (c == '0 && r >= FRAME_H_W'(2))
            begin
                ctrl_next.has_result = 1'b1;
                ctrl_next.sel        = SEL_ABOVE_END;
                ctrl_next.row_end    = 1'b1;
            end
            pend_next = '0;
            if (c_inc >= {1'b0, eff_w})
            begin
                col_next = '0;
                if (r_inc >= {1'b0, eff_h})
                begin
                    row_next  = '0;
                    pend_next = PW'(eff_w) + PW'(1);
                end
                else
                    row_next = r_inc[FRAME_H_W-1:0];
            end
            else
                col_next = c_inc[WW-1:0];
        end
        else if (flushed)
        begin
            addr_c               = d_m1[AW-1:0];
            ctrl_next.has_result = 1'b1;
            ctrl_next.sel        = (col_reg == '0) ? SEL_ABOVE_END : SEL_CURRENT;
            ctrl_next.row_end    = (col_reg == '0) || last;
            ctrl_next.frame_end  = last;
            pend_next            = pend_reg - 1'b1;
            col_next             = last ? '0 : WW'(col_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                pend_reg     <= pend_next;
                s1_ctrl_reg  <= ctrl_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_addr_reg <= addr_c;
            s1_pix_reg  <= pixel_in;
        end
    end

    // line buffers, one-deep bypass for the write that lands on the read edge
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            above_mem[s1_addr_reg] <= b_eff;
            cur_mem[s1_addr_reg]   <= s1_pix_reg;
        end
        if (in_acc)
        begin
            above_a_rd_reg <= above_mem[addr_a];
            above_b_rd_reg <= above_mem[addr_b];
            cur_rd_reg     <= cur_mem[addr_c];
            fwd_a_reg      <= mem_we && (s1_addr_reg == addr_a);
            fwd_b_reg      <= mem_we && (s1_addr_reg == addr_b);
            fwd_c_reg      <= mem_we && (s1_addr_reg == addr_c);
            fwd_above_reg  <= b_eff;
            fwd_cur_reg    <= s1_pix_reg;
        end
    end

    assign a_eff  = fwd_a_reg ? fwd_above_reg : above_a_rd_reg;
    assign p_eff  = fwd_b_reg ? fwd_above_reg : above_b_rd_reg;
    assign b_eff  = fwd_c_reg ? fwd_cur_reg : cur_rd_reg;
    assign centre = window_reg[1][2];

    // 8 * centre plus the eight neighbors of the shifted window
    always_comb
    begin
        sum = {1'b0, centre, 3'b000}
            + 12'(window_reg[0][1]) + 12'(window_reg[0][2]) + 12'(a_eff)
            + 12'(window_reg[1][1]) + 12'(b_eff)
            + 12'(window_reg[2][1]) + 12'(window_reg[2][2]) + 12'(s1_pix_reg);
        case (s1_ctrl_reg.sel)
            SEL_WINDOW:    result_val = s1_ctrl_reg.avg ? sum[11:4] : centre;
            SEL_ABOVE_END: result_val = p_eff;
            SEL_CURRENT:   result_val = b_eff;
            default:       result_val = centre;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int y = 0; y < 3; y++)
            begin
                for (int x = 0; x < 3; x++)
                begin
                    window_reg[y][x] <= '0;
                end
            end
        end
        else if (mem_we)
        begin
            for (int y = 0; y < 3; y++)
            begin
                window_reg[y][0] <= window_reg[y][1];
                window_reg[y][1] <= window_reg[y][2];
            end
            window_reg[0][2] <= a_eff;
            window_reg[1][2] <= b_eff;
            window_reg[2][2] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_ctrl_reg.has_result)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_ctrl_reg.has_result)
        begin
            pixel_out_reg <= result_val;
            row_end_reg   <= s1_ctrl_reg.row_end;
            frame_end_reg <= s1_ctrl_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule
`default_nettype wire
